// File: rtl/mrf_pkg.sv
`timescale 1ns / 1ps

package mrf_pkg;

  // configuration register widths and indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int FREQ_W     = 23;
  localparam int QUAL_W     = 18;
  localparam int RATE_W     = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_FREQ = 2'd0,
    CFG_QUALITY     = 2'd1,
    CFG_SAMPLE_RATE = 2'd2
  } cfg_idx_e;

  localparam logic [FREQ_W-1:0] FREQ_RST = 23'd128000;
  localparam logic [QUAL_W-1:0] QUAL_RST = 18'd12800;
  localparam logic [RATE_W-1:0] RATE_RST = 18'd48000;

  // fixed-point formats
  localparam int COEF_W  = 48;
  localparam int SCALE_W = 32;
  localparam int D_FRAC  = 16;
  localparam int WIDE_W  = 63;
  localparam int TERM_W  = 61;

  localparam logic [23:0]       FOUR_PI_Q20 = 24'd13176795;
  localparam logic [WIDE_W-1:0] WIDE_CAP    = 63'd1 << 62;
  localparam logic [TERM_W-1:0] TERM_CAP    = 61'd1 << 60;
  localparam logic [63:0]       ONE_Q32     = 64'h0000_0001_0000_0000;
  localparam logic signed [63:0] Y_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Y_MIN      = -64'sh0000_8000_0000_0000;

  // digit-serial multiplier
  localparam int MUL_W     = 48;
  localparam int MUL_DIGIT = 4;
  localparam int PROD_W    = 2 * MUL_W;

  // bit-serial divider
  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = 8;
  localparam logic [DIV_CNT_W-1:0] D_SHIFT  = 8'd44;
  localparam logic [DIV_CNT_W-1:0] DQ_SHIFT = 8'd24;

  typedef enum logic [1:0] {
    DIV_CAP_SCALE,
    DIV_CAP_COEF,
    DIV_CAP_NONE
  } div_cap_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FQ_MUL,
    ST_D_DIV,
    ST_BETA_MUL,
    ST_BETA,
    ST_DQ_DIV,
    ST_DEN,
    ST_C0_DIV,
    ST_C1_DIV,
    ST_C2_DIV,
    ST_T0_MUL,
    ST_T0_ACC,
    ST_T1_MUL,
    ST_T1_ACC,
    ST_T2_MUL,
    ST_T2_ACC,
    ST_Y,
    ST_O_MUL,
    ST_O
  } mrf_state_e;

endpackage

// File: rtl/mrf_in_if.sv
`timescale 1ns / 1ps

interface mrf_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// File: rtl/mrf_out_if.sv
`timescale 1ns / 1ps

interface mrf_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/mrf_mul.sv
`timescale 1ns / 1ps

module mrf_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mrf_pkg::MUL_W-1:0]      a_i,
  input  logic [mrf_pkg::MUL_W-1:0]      b_i,
  output logic                           done_o,
  output logic [mrf_pkg::PROD_W-1:0]     p_o
);
  localparam int W     = mrf_pkg::MUL_W;
  localparam int DG    = mrf_pkg::MUL_DIGIT;
  localparam int STEPS = W / DG;
  localparam int CW    = $clog2(STEPS);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  a_q, b_q, acc_q, lo_q;
  logic [W+DG-1:0] part, sum;

  // one digit of b times a, added to the running high part
  assign part = a_q * b_q[DG-1:0];
  assign sum  = {{DG{1'b0}}, acc_q} + part;

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // low product digits shift out into lo_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      lo_q  <= '0;
    end else if (busy_q) begin
      acc_q <= sum[W+DG-1:DG];
      lo_q  <= {sum[DG-1:0], lo_q[W-1:DG]};
      b_q   <= b_q >> DG;
    end
  end

  assign done_o = done_q;
  assign p_o    = {acc_q, lo_q};

endmodule

// File: rtl/mrf_div.sv
`timescale 1ns / 1ps

module mrf_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [mrf_pkg::DIV_W-1:0]        num_i,
  input  logic [mrf_pkg::DIV_CNT_W-1:0]    shift_i,
  input  logic [mrf_pkg::WIDE_W-1:0]       den_i,
  input  mrf_pkg::div_cap_e                cap_i,
  output logic                             done_o,
  output logic [mrf_pkg::DIV_W-1:0]        q_o
);
  localparam int W  = mrf_pkg::DIV_W;
  localparam int DW = mrf_pkg::WIDE_W;
  localparam int CW = mrf_pkg::DIV_CNT_W;
  localparam int SW = mrf_pkg::SCALE_W;
  localparam int KW = mrf_pkg::COEF_W - 1;

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q, last_q;
  mrf_pkg::div_cap_e cap_q;
  logic              ovf_q;
  logic [W-1:0]      num_q, q_q;
  logic [DW-1:0]     den_q, rem_q;
  logic [W-1:0]      r, diff;
  logic              ge, top_bit;

  // one restoring step per cycle
  assign r    = {rem_q, num_q[W-1]};
  assign ge   = r >= {1'b0, den_q};
  assign diff = r - {1'b0, den_q};

  // quotient bit leaving the capped range
  always_comb begin
    case (cap_q)
      mrf_pkg::DIV_CAP_SCALE: top_bit = q_q[SW-1];
      mrf_pkg::DIV_CAP_COEF:  top_bit = q_q[KW-1];
      default:                top_bit = q_q[W-1];
    endcase
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == last_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out msb first, zeros follow for the extra fraction bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      q_q    <= '0;
      ovf_q  <= 1'b0;
      cap_q  <= cap_i;
      last_q <= CW'(W) + shift_i - 1'b1;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? diff[DW-1:0] : r[DW-1:0];
      q_q   <= {q_q[W-2:0], ge};
      ovf_q <= ovf_q | top_bit;
    end
  end

  // quotient, saturated for the scale and coefficient caps
  always_comb begin
    case (cap_q)
      mrf_pkg::DIV_CAP_SCALE:
        q_o = ovf_q ? {{(W-SW){1'b0}}, {SW{1'b1}}} : {{(W-SW){1'b0}}, q_q[SW-1:0]};
      mrf_pkg::DIV_CAP_COEF:
        q_o = ovf_q ? {{(W-KW){1'b0}}, {KW{1'b1}}} : {{(W-KW){1'b0}}, q_q[KW-1:0]};
      default:
        q_o = q_q;
    endcase
  end

  assign done_o = done_q;

endmodule

// File: rtl/mode_resonant_filter.sv
`timescale 1ns / 1ps
// each sample takes four products on the shared 4-bit-digit multiplier; a new sample is
//   accepted only once the previous output word has been loaded
// after reset or a register write the next sample first updates the coefficients:
//   two products and five bit-serial divisions
// reset: asynchronous active low; registers to defaults, history cleared, coefficients stale

module mode_resonant_filter #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  mrf_in_if.sink                            in_i,
  mrf_out_if.source                         out_o
);
  localparam int SW        = SAMPLE_WIDTH;
  localparam int CW        = mrf_pkg::COEF_W;
  localparam int MW        = mrf_pkg::MUL_W;
  localparam int PW        = mrf_pkg::PROD_W;
  localparam int DW        = mrf_pkg::DIV_W;
  localparam int WW        = mrf_pkg::WIDE_W;
  localparam int KW        = mrf_pkg::DIV_CNT_W;
  localparam int TW        = mrf_pkg::TERM_W;
  localparam int OUT_SHIFT = FRAC_BITS + mrf_pkg::D_FRAC - (SW - 1);
  localparam logic [PW-1:0] OUT_LIM  = PW'(1) << (SW - 1);
  localparam logic [PW-1:0] BETA_LIM = PW'(1) << 60;

  function automatic logic [MW-1:0] mag48(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  mrf_pkg::mrf_state_e state_q, state_d;
  logic launch_q, coefs_ok_q;

  logic [mrf_pkg::FREQ_W-1:0] freq_q, freq_nz;
  logic [mrf_pkg::QUAL_W-1:0] qual_q, qual_nz;
  logic [mrf_pkg::RATE_W-1:0] rate_q;

  logic signed [SW-1:0] px_q, x_q;
  logic signed [CW-1:0] y1_q, y2_q, c0_q, c1_q, c2_q;
  logic [mrf_pkg::SCALE_W-1:0] scale_q;
  logic [WW-1:0] beta_q, dq_q, den_q;
  logic signed [63:0] yacc_q;

  logic out_valid_q;
  logic [SW-1:0] out_data_q;

  // unit handshakes
  logic          mul_start, mul_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_q;
  logic [KW-1:0] div_shift;
  logic [WW-1:0] div_den;
  mrf_pkg::div_cap_e div_cap;

  logic in_acc, out_load;
  logic [MW-1:0] px_mag;
  logic [CW-1:0] px_ext;
  logic [63:0] twob, c1_mag, c2_mag, den_sum;
  logic c1_neg, c2_neg;
  logic [PW-1:0] prod_sh;
  logic [TW-1:0] term_mag;
  logic term_neg, contrib_neg;
  logic signed [63:0] contrib, yacc_d;
  logic signed [CW-1:0] y_sat;
  logic [SW-1:0] out_word;

  mrf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  mrf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .shift_i (div_shift),
    .den_i   (div_den),
    .cap_i   (div_cap),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // operand preparation
  assign freq_nz = (freq_q == '0) ? mrf_pkg::FREQ_W'(1) : freq_q;
  assign qual_nz = (qual_q == '0) ? mrf_pkg::QUAL_W'(1) : qual_q;
  assign px_ext  = {{(CW-SW){px_q[SW-1]}}, px_q};
  assign px_mag  = mag48(px_ext);

  assign twob    = {beta_q, 1'b0};
  assign c1_neg  = twob >= mrf_pkg::ONE_Q32;
  assign c1_mag  = c1_neg ? (twob - mrf_pkg::ONE_Q32) : (mrf_pkg::ONE_Q32 - twob);
  assign c2_neg  = dq_q > beta_q;
  assign c2_mag  = c2_neg ? {1'b0, dq_q - beta_q} : {1'b0, beta_q - dq_q};
  assign den_sum = {1'b0, beta_q} + {1'b0, dq_q};

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == mrf_pkg::ST_O) && (!out_valid_q || out_o.ready);

  // product alignment for the term in hand
  always_comb begin
    case (state_q)
      mrf_pkg::ST_T0_ACC: prod_sh = mul_p >> (SW - 1);
      mrf_pkg::ST_O:      prod_sh = mul_p >> OUT_SHIFT;
      default:            prod_sh = mul_p >> FRAC_BITS;
    endcase
  end

  assign term_mag = (prod_sh > PW'(mrf_pkg::TERM_CAP)) ? mrf_pkg::TERM_CAP : prod_sh[TW-1:0];

  always_comb begin
    case (state_q)
      mrf_pkg::ST_T0_ACC: term_neg = c0_q[CW-1] ^ px_q[SW-1];
      mrf_pkg::ST_T1_ACC: term_neg = c1_q[CW-1] ^ y1_q[CW-1];
      mrf_pkg::ST_T2_ACC: term_neg = c2_q[CW-1] ^ y2_q[CW-1];
      default:            term_neg = y1_q[CW-1];
    endcase
  end

  // feedback terms are subtracted
  assign contrib_neg = (state_q == mrf_pkg::ST_T0_ACC) ? term_neg : !term_neg;
  assign contrib     = contrib_neg ? -$signed({3'b000, term_mag}) : $signed({3'b000, term_mag});
  assign yacc_d      = ((state_q == mrf_pkg::ST_T0_ACC) ? 64'sd0 : yacc_q) + contrib;

  // history saturation to 48 bits
  always_comb begin
    if (yacc_q > mrf_pkg::Y_MAX) begin
      y_sat = mrf_pkg::Y_MAX[CW-1:0];
    end else if (yacc_q < mrf_pkg::Y_MIN) begin
      y_sat = mrf_pkg::Y_MIN[CW-1:0];
    end else begin
      y_sat = yacc_q[CW-1:0];
    end
  end

  // output scaling and saturation to the sample range
  always_comb begin
    if (!y1_q[CW-1]) begin
      out_word = (prod_sh >= OUT_LIM) ? {1'b0, {(SW-1){1'b1}}} : prod_sh[SW-1:0];
    end else begin
      out_word = (prod_sh > OUT_LIM) ? {1'b1, {(SW-1){1'b0}}} : (~prod_sh[SW-1:0] + 1'b1);
    end
  end

  // sequencer next state and unit operands
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_shift = '0;
    div_den   = '0;
    div_cap   = mrf_pkg::DIV_CAP_NONE;
    case (state_q)
      mrf_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = coefs_ok_q ? mrf_pkg::ST_T0_MUL : mrf_pkg::ST_FQ_MUL;
        end
      end
      mrf_pkg::ST_FQ_MUL: begin
        mul_start = !launch_q;
        mul_a     = MW'(freq_nz);
        mul_b     = MW'(mrf_pkg::FOUR_PI_Q20);
        if (mul_done) state_d = mrf_pkg::ST_D_DIV;
      end
      mrf_pkg::ST_D_DIV: begin
        div_start = !launch_q;
        div_num   = DW'(rate_q);
        div_shift = mrf_pkg::D_SHIFT;
        div_den   = mul_p[WW-1:0];
        div_cap   = mrf_pkg::DIV_CAP_SCALE;
        if (div_done) state_d = mrf_pkg::ST_BETA_MUL;
      end
      mrf_pkg::ST_BETA_MUL: begin
        mul_start = !launch_q;
        mul_a     = MW'(scale_q);
        mul_b     = MW'(scale_q);
        if (mul_done) state_d = mrf_pkg::ST_BETA;
      end
      mrf_pkg::ST_BETA: begin
        state_d = mrf_pkg::ST_DQ_DIV;
      end
      mrf_pkg::ST_DQ_DIV: begin
        div_start = !launch_q;
        div_num   = DW'(scale_q);
        div_shift = mrf_pkg::DQ_SHIFT;
        div_den   = WW'(qual_nz);
        div_cap   = mrf_pkg::DIV_CAP_NONE;
        if (div_done) state_d = mrf_pkg::ST_DEN;
      end
      mrf_pkg::ST_DEN: begin
        state_d = mrf_pkg::ST_C0_DIV;
      end
      mrf_pkg::ST_C0_DIV: begin
        div_start = !launch_q;
        div_num   = DW'(1);
        div_shift = KW'(32 + FRAC_BITS);
        div_den   = den_q;
        div_cap   = mrf_pkg::DIV_CAP_COEF;
        if (div_done) state_d = mrf_pkg::ST_C1_DIV;
      end
      mrf_pkg::ST_C1_DIV: begin
        div_start = !launch_q;
        div_num   = c1_mag;
        div_shift = KW'(FRAC_BITS);
        div_den   = den_q;
        div_cap   = mrf_pkg::DIV_CAP_COEF;
        if (div_done) state_d = mrf_pkg::ST_C2_DIV;
      end
      mrf_pkg::ST_C2_DIV: begin
        div_start = !launch_q;
        div_num   = c2_mag;
        div_shift = KW'(FRAC_BITS);
        div_den   = den_q;
        div_cap   = mrf_pkg::DIV_CAP_COEF;
        if (div_done) state_d = mrf_pkg::ST_T0_MUL;
      end
      mrf_pkg::ST_T0_MUL: begin
        mul_start = !launch_q;
        mul_a     = mag48(c0_q);
        mul_b     = px_mag;
        if (mul_done) state_d = mrf_pkg::ST_T0_ACC;
      end
      mrf_pkg::ST_T0_ACC: state_d = mrf_pkg::ST_T1_MUL;
      mrf_pkg::ST_T1_MUL: begin
        mul_start = !launch_q;
        mul_a     = mag48(c1_q);
        mul_b     = mag48(y1_q);
        if (mul_done) state_d = mrf_pkg::ST_T1_ACC;
      end
      mrf_pkg::ST_T1_ACC: state_d = mrf_pkg::ST_T2_MUL;
      mrf_pkg::ST_T2_MUL: begin
        mul_start = !launch_q;
        mul_a     = mag48(c2_q);
        mul_b     = mag48(y2_q);
        if (mul_done) state_d = mrf_pkg::ST_T2_ACC;
      end
      mrf_pkg::ST_T2_ACC: state_d = mrf_pkg::ST_Y;
      mrf_pkg::ST_Y:      state_d = mrf_pkg::ST_O_MUL;
      mrf_pkg::ST_O_MUL: begin
        mul_start = !launch_q;
        mul_a     = mag48(y1_q);
        mul_b     = MW'(scale_q);
        if (mul_done) state_d = mrf_pkg::ST_O;
      end
      mrf_pkg::ST_O: begin
        if (out_load) state_d = mrf_pkg::ST_IDLE;
      end
      default: state_d = mrf_pkg::ST_IDLE;
    endcase
  end

  // control state, registers and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrf_pkg::ST_IDLE;
      launch_q    <= 1'b0;
      coefs_ok_q  <= 1'b0;
      freq_q      <= mrf_pkg::FREQ_RST;
      qual_q      <= mrf_pkg::QUAL_RST;
      rate_q      <= mrf_pkg::RATE_RST;
      px_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) begin
        launch_q <= 1'b1;
      end else if (mul_done || div_done) begin
        launch_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (mrf_pkg::cfg_idx_e'(cfg_idx_i))
          mrf_pkg::CFG_CENTRE_FREQ: begin
            freq_q     <= cfg_data_i[mrf_pkg::FREQ_W-1:0];
            coefs_ok_q <= 1'b0;
          end
          mrf_pkg::CFG_QUALITY: begin
            qual_q     <= cfg_data_i[mrf_pkg::QUAL_W-1:0];
            coefs_ok_q <= 1'b0;
          end
          mrf_pkg::CFG_SAMPLE_RATE: begin
            rate_q     <= cfg_data_i[mrf_pkg::RATE_W-1:0];
            coefs_ok_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == mrf_pkg::ST_C2_DIV && div_done) begin
        coefs_ok_q <= 1'b1;
      end
      if (state_q == mrf_pkg::ST_Y) begin
        px_q <= x_q;
        y2_q <= y1_q;
        y1_q <= y_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // coefficient and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) x_q <= in_i.sample_in;
    if (state_q == mrf_pkg::ST_D_DIV && div_done) scale_q <= div_q[mrf_pkg::SCALE_W-1:0];
    if (state_q == mrf_pkg::ST_BETA) begin
      beta_q <= (scale_q[mrf_pkg::SCALE_W-1] || mul_p >= BETA_LIM) ?
                mrf_pkg::WIDE_CAP : {mul_p[WW-3:0], 2'b00};
    end
    if (state_q == mrf_pkg::ST_DQ_DIV && div_done) dq_q <= div_q[WW-1:0];
    if (state_q == mrf_pkg::ST_DEN) begin
      if (den_sum > 64'(mrf_pkg::WIDE_CAP)) begin
        den_q <= mrf_pkg::WIDE_CAP;
      end else if (den_sum == '0) begin
        den_q <= WW'(1);
      end else begin
        den_q <= den_sum[WW-1:0];
      end
    end
    if (state_q == mrf_pkg::ST_C0_DIV && div_done) c0_q <= div_q[CW-1:0];
    if (state_q == mrf_pkg::ST_C1_DIV && div_done) begin
      c1_q <= c1_neg ? (~div_q[CW-1:0] + 1'b1) : div_q[CW-1:0];
    end
    if (state_q == mrf_pkg::ST_C2_DIV && div_done) begin
      c2_q <= c2_neg ? (~div_q[CW-1:0] + 1'b1) : div_q[CW-1:0];
    end
    if (state_q == mrf_pkg::ST_T0_ACC || state_q == mrf_pkg::ST_T1_ACC ||
        state_q == mrf_pkg::ST_T2_ACC) begin
      yacc_q <= yacc_d;
    end
    if (out_load) out_data_q <= out_word;
  end

  assign in_i.ready       = (state_q == mrf_pkg::ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

endmodule

// File: rtl/mrf_checker.sv
`timescale 1ns / 1ps

module mrf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] out_data_i
);

  // a stalled output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output word changed while stalled");

  // one sample in work at a time
  a_in_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample taken while busy");

  // a new output word is loaded as the block goes back to idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("output word appeared while still busy");

endmodule

bind mode_resonant_filter mrf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.sample_out)
);

// File: tb/mode_resonant_filter_checker.sv
`timescale 1ns / 1ps

module mode_resonant_filter_checker #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mrf_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_out_i,
  output int                                   errors_o,
  output int                                   pending_o
);

  localparam logic [63:0] COEF_LIM  = (64'd1 << 47) - 64'd1;
  localparam logic [63:0] TERM_LIM  = 64'd1 << 60;
  localparam logic [63:0] WIDE_LIM  = 64'd1 << 62;
  localparam int          OUT_SHIFT = FRAC_BITS + 16 - (SAMPLE_WIDTH - 1);

  // register copies and filter state
  logic [mrf_pkg::FREQ_W-1:0] freq_q;
  logic [mrf_pkg::QUAL_W-1:0] qual_q;
  logic [mrf_pkg::RATE_W-1:0] rate_q;
  longint                     x_prev, y_one, y_two, a0, a1, a2;
  logic [31:0]                d_scale;
  logic                       coefs_ok;

  logic signed [SAMPLE_WIDTH-1:0] filtered_q[$];

  // floor(num * 2^sh / den), limited to cap
  function automatic logic [63:0] div_sat(logic [63:0] num, int sh, logic [63:0] den,
                                          logic [63:0] cap);
    logic [63:0] rem, quo;
    logic        b;
    rem = '0;
    quo = '0;
    if (den == 0) return cap;
    for (int i = 0; i < 64 + sh; i++) begin
      b   = (i < 64) ? num[63-i] : 1'b0;
      rem = {rem[62:0], b};
      quo = {quo[62:0], 1'b0};
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
      if (quo > cap) return cap;
    end
    return quo;
  endfunction

  // signed product, magnitude truncated after the shift and limited
  function automatic longint prod_q(longint a, longint b, int sh);
    logic         neg;
    logic [63:0]  ua, ub, r;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = {64'd0, ua} * {64'd0, ub};
    p   = p >> sh;
    r   = (p > {64'd0, TERM_LIM}) ? TERM_LIM : p[63:0];
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint lim;
    lim = (longint'(1) <<< (bits - 1)) - 1;
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  function automatic longint coef_quot(logic neg, logic [63:0] mag, logic [63:0] den);
    longint r;
    r = longint'(div_sat(mag, FRAC_BITS, den, COEF_LIM));
    return neg ? -r : r;
  endfunction

  // coefficients from frequency, quality and rate
  task automatic update_coefs();
    logic [63:0] fq, qq, dd, beta, dq, den, twob, one;
    one  = 64'd1 << 32;
    fq   = (freq_q == 0) ? 64'd1 : 64'(freq_q);
    qq   = (qual_q == 0) ? 64'd1 : 64'(qual_q);
    dd   = div_sat(64'(rate_q), 44, fq * 64'(mrf_pkg::FOUR_PI_Q20), 64'hFFFF_FFFF);
    d_scale = dd[31:0];
    beta = (dd >= (64'd1 << 31)) ? WIDE_LIM : 64'd4 * dd * dd;
    if (beta > WIDE_LIM) beta = WIDE_LIM;
    dq = (dd << 24) / qq;
    if (dq > WIDE_LIM) dq = WIDE_LIM;
    den = beta + dq;
    if (den > WIDE_LIM) den = WIDE_LIM;
    if (den == 0) den = 64'd1;
    a0   = longint'(div_sat(64'd1, 32 + FRAC_BITS, den, COEF_LIM));
    twob = 64'd2 * beta;
    a1   = (twob >= one) ? coef_quot(1'b1, twob - one, den) : coef_quot(1'b0, one - twob, den);
    a2   = (beta >= dq) ? coef_quot(1'b0, beta - dq, den) : coef_quot(1'b1, dq - beta, den);
    coefs_ok = 1'b1;
  endtask

  // one sample through the resonator
  task automatic filter_step(logic signed [SAMPLE_WIDTH-1:0] s);
    longint y, o;
    if (!coefs_ok) update_coefs();
    y = prod_q(a0, x_prev, SAMPLE_WIDTH - 1) - prod_q(a1, y_one, FRAC_BITS)
        - prod_q(a2, y_two, FRAC_BITS);
    y = clamp(y, 48);
    x_prev = longint'(s);
    y_two  = y_one;
    y_one  = y;
    o = clamp(prod_q(y, longint'(d_scale), OUT_SHIFT), SAMPLE_WIDTH);
    filtered_q.push_back(o[SAMPLE_WIDTH-1:0]);
  endtask

  assign pending_o = filtered_q.size();

  // follow config, predict on input words, compare output words
  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (!rst_ni) begin
      freq_q   = mrf_pkg::FREQ_RST;
      qual_q   = mrf_pkg::QUAL_RST;
      rate_q   = mrf_pkg::RATE_RST;
      x_prev   = 0;
      y_one    = 0;
      y_two    = 0;
      a0       = 0;
      a1       = 0;
      a2       = 0;
      d_scale  = '0;
      coefs_ok = 1'b0;
      errors_o <= 0;
      filtered_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mrf_pkg::CFG_CENTRE_FREQ: begin
            freq_q   = cfg_data_i[mrf_pkg::FREQ_W-1:0];
            coefs_ok = 1'b0;
          end
          mrf_pkg::CFG_QUALITY: begin
            qual_q   = cfg_data_i[mrf_pkg::QUAL_W-1:0];
            coefs_ok = 1'b0;
          end
          mrf_pkg::CFG_SAMPLE_RATE: begin
            rate_q   = cfg_data_i[mrf_pkg::RATE_W-1:0];
            coefs_ok = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) filter_step(sample_in_i);
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected output word %0d", sample_out_i);
          errors_o <= errors_o + 1;
        end else begin
          want = filtered_q.pop_front();
          if (want !== sample_out_i) begin
            if (errors_o < 10)
              $display("sample_out mismatch: expected %0d got %0d", want, sample_out_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/mode_resonant_filter_tb.sv
`timescale 1ns / 1ps

module mode_resonant_filter_tb;

  localparam int                            SW        = 16;
  localparam int                            STALL_LIM = 8000;
  localparam int                            DW        = mrf_pkg::CFG_DATA_W;
  localparam logic [mrf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [mrf_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [DW-1:0]                  cfg_data_i = '0;
  int                             errors, pending;
  logic                           quiet = 1'b0;
  logic                           hold_go = 1'b0;
  logic                           hold_used = 1'b0;
  int                             hold_left = 0;
  int                             stuck = 0;

  mrf_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  mrf_out_if #(.SAMPLE_WIDTH(SW)) out_if ();

  mode_resonant_filter #(.SAMPLE_WIDTH(SW), .FRAC_BITS(40)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_if), .out_o(out_if)
  );

  mode_resonant_filter_checker #(.SAMPLE_WIDTH(SW), .FRAC_BITS(40)) chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .sample_in_i(in_if.sample_in),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .sample_out_i(out_if.sample_out),
    .errors_o(errors), .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
  end

  // output side: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  // watchdog on words moving either way
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STALL_LIM) begin
      $display("mode_resonant_filter_tb: errors");
      $finish;
    end
  end

  task automatic send_word(logic signed [SW-1:0] s);
    while (!quiet && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] rand_word();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return SW'($urandom);
    if (sel < 7) return SW'($signed($urandom_range(512)) - 256);
    if (sel < 8) return ($urandom_range(1) != 0) ? 16'sh7FFF : -16'sh8000;
    return '0;
  endfunction

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [DW-1:0] f, logic [DW-1:0] q, logic [DW-1:0] r);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= mrf_pkg::CFG_CENTRE_FREQ;
    cfg_data_i <= f;
    @(posedge clk_i);
    cfg_idx_i <= mrf_pkg::CFG_QUALITY;
    cfg_data_i <= q;
    @(posedge clk_i);
    cfg_idx_i <= mrf_pkg::CFG_SAMPLE_RATE;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic signed [SW-1:0] directed[] = '{16'sh7FFF, 0, 0, 0, -16'sh8000, 0, 0, 16'sh7FFF,
                                         16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 1,
                                         -1, 16'sh5555, -16'sh5556, 0, 0, 0, 0};
    logic [DW-1:0] f, q, r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, directed samples then random
    foreach (directed[i]) send_word(directed[i]);
    for (int i = 0; i < 140; i++) send_word(rand_word());
    drain();

    for (int ph = 1; ph <= 12; ph++) begin
      case (ph)
        1: begin f = 23'd256; q = 23'd256; r = 23'd8000; end
        2: begin f = 23'd6144000; q = 23'd256000; r = 23'd192000; end
        3: begin f = 23'd0; q = 23'd0; r = 23'd48000; end
        4: begin f = 23'd128000; q = 23'd12800; r = 23'd0; end
        5: begin f = 23'h7FFFFF; q = 23'h3FFFF; r = 23'h3FFFF; end
        default: begin
          f = DW'($urandom_range(6144000, 256));
          q = DW'($urandom_range(256000, 256));
          r = DW'($urandom_range(192000, 8000));
        end
      endcase
      write_regs(f, q, r);
      // a write to the spare index must change nothing
      if (ph == 5) begin
        cfg_we_i <= 1'b1;
        cfg_idx_i <= CFG_SPARE;
        cfg_data_i <= 23'h2AAAAA;
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      quiet <= (ph == 2);
      if (ph == 6) hold_go <= 1'b1;
      for (int i = 0; i < 150; i++) send_word(rand_word());
      drain();
    end

    if (errors == 0) begin
      $display("mode_resonant_filter_tb: clean");
    end else begin
      $display("mode_resonant_filter_tb: errors");
    end
    $finish;
  end

endmodule
